// ===== design/tdtq_pkg.sv =====
package tdtq_pkg;

  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_IRQ   = 2'd1;
  localparam logic [1:0] FUNC_SLEEP = 2'd2;

  localparam logic [1:0] KIND_WAKE   = 2'd0;
  localparam logic [1:0] KIND_PROG   = 2'd1;
  localparam logic [1:0] KIND_ACCEPT = 2'd2;
  localparam logic [1:0] KIND_FULL   = 2'd3;

  localparam logic [1:0] CFG_INTERVAL = 2'd0;
  localparam logic [1:0] CFG_MULT     = 2'd1;
  localparam logic [1:0] CFG_SHIFT    = 2'd2;

  localparam logic [29:0] INTERVAL_RST = 30'd10000000;
  localparam logic [63:0] MULT_RST     = 64'h0000_0001_0000_0000;
  localparam logic [5:0]  SHIFT_RST    = 6'd32;
  localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_IRQ   = 2'd1,
    OP_SLEEP = 2'd2
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_ZERO,
    S_POP,
    S_TICK,
    S_RESYNC,
    S_EVENT,
    S_DELTA,
    S_GO,
    S_WAIT,
    S_INS
  } state_e;

  typedef struct packed {
    op_e         op;
    logic [63:0] now;
    logic [7:0]  task_id;
    logic [63:0] deadline;
  } item_t;

  typedef struct packed {
    logic [29:0] interval;
    logic [63:0] mult;
    logic [5:0]  shift;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  woken;
    logic [31:0] count;
    logic        expired;
    logic        last;
  } res_t;

endpackage

// ===== design/tdtq_in_if.sv =====
interface tdtq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [63:0] now_ns;
  logic [7:0]  task_id;
  logic [63:0] wake_deadline;

  modport source (output valid, func, now_ns, task_id, wake_deadline, input ready);
  modport sink (input valid, func, now_ns, task_id, wake_deadline, output ready);
endinterface

// ===== design/tdtq_out_if.sv =====
interface tdtq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  woken_task;
  logic [31:0] timer_count;
  logic        tick_passed;
  logic        last;

  modport source (output valid, kind, woken_task, timer_count, tick_passed, last,
                  input ready);
  modport sink (input valid, kind, woken_task, timer_count, tick_passed, last,
                output ready);
endinterface

// ===== design/tdtq_front.sv =====
module tdtq_front
  import tdtq_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  logic  [1:0] func_i,
  input  logic  [63:0] now_i,
  input  logic  [7:0] task_i,
  input  logic  [63:0] deadline_i,
  output logic  item_valid_o,
  output item_t item_o,
  input  logic  item_take_i
);

  item_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       keep, push;
  item_t      cls;

  always_comb begin
    keep   = 1'b1;
    cls.op = OP_START;
    unique case (func_i)
      FUNC_START: cls.op = OP_START;
      FUNC_IRQ:   cls.op = OP_IRQ;
      FUNC_SLEEP: cls.op = OP_SLEEP;
      default:    keep = 1'b0;
    endcase
    cls.now      = now_i;
    cls.task_id  = task_i;
    cls.deadline = deadline_i;
  end

  assign in_ready_o   = cnt_q != 2'd2;
  assign push         = in_valid_i && in_ready_o && keep;
  assign item_valid_o = cnt_q != 2'd0;
  assign item_o       = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (item_take_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, item_take_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= cls;
  end

endmodule

// ===== design/tdtq_scale.sv =====
module tdtq_scale
  import tdtq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] delta_i,
  input  logic [63:0] mult_i,
  input  logic [5:0]  shift_i,
  output logic        done_o,
  output logic [31:0] count_o
);

  logic         busy_q, done_q;
  logic [2:0]   step_q;
  logic [63:0]  a_q, p_q;
  logic [1:0]   off_q;
  logic [127:0] acc_q, sh_q;
  logic [31:0]  a_sel, b_sel;
  logic [63:0]  prod;

  always_comb begin
    a_sel = step_q[0] ? a_q[63:32] : a_q[31:0];
    b_sel = step_q[1] ? mult_i[63:32] : mult_i[31:0];
    prod  = a_sel * b_sel;
    if (|sh_q[127:32]) count_o = COUNT_MAX;
    else if (sh_q[31:0] == 32'd0) count_o = 32'd1;
    else count_o = sh_q[31:0];
  end

  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= 3'd0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= 3'd0;
    end else if (busy_q) begin
      step_q <= step_q + 3'd1;
      if (step_q == 3'd5) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= delta_i;
      acc_q <= '0;
    end else if (busy_q) begin
      if (step_q <= 3'd3) begin
        p_q   <= prod;
        off_q <= {1'b0, step_q[0]} + {1'b0, step_q[1]};
      end
      if (step_q >= 3'd1 && step_q <= 3'd4) begin
        acc_q <= acc_q + ({64'd0, p_q} << {off_q, 5'd0});
      end
      if (step_q == 3'd5) sh_q <= acc_q >> shift_i;
    end
  end

endmodule

// ===== design/tdtq_back.sv =====
module tdtq_back
  import tdtq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  item_valid_i,
  input  item_t item_i,
  output logic  item_take_o,
  output logic  res_valid_o,
  output res_t  res_o,
  input  logic  res_ready_i
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  state_e      state_q, state_d;
  item_t       cur_q, cur_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [63:0] ntick_q, ntick_d, prog_q, prog_d, target_q, target_d;
  logic [63:0] delta_q, delta_d, nt1_q, nt1_d;
  logic        exp_q, exp_d;
  logic        ov_q, ov_d;
  res_t        res_q, res_d, emit_res;
  logic        emit, emit_ok, ins_en, pop_en, scale_start;
  logic        full, front_hit, sooner;
  logic [63:0] dl_q [QUEUE_DEPTH];
  logic [7:0]  tk_q [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] ge;
  logic        sc_done;
  logic [31:0] sc_count;
  logic [63:0] iv64;

  tdtq_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scale_start),
    .delta_i (delta_q),
    .mult_i  (cfg_i.mult),
    .shift_i (cfg_i.shift),
    .done_o  (sc_done),
    .count_o (sc_count)
  );

  assign iv64      = {34'd0, cfg_i.interval};
  assign full      = cnt_q == CW'(QUEUE_DEPTH);
  assign front_hit = (cnt_q != '0) && (dl_q[0] <= cur_q.now);
  assign sooner    = cur_q.deadline < prog_q;
  assign emit_ok   = !ov_q || res_ready_i;

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ge[i] = (CW'(i) < cnt_q) && (dl_q[i] <= cur_q.deadline);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          unique case (item_i.op)
            OP_START: state_d = S_START;
            OP_IRQ:   state_d = (item_i.now == 64'd0) ? S_ZERO : S_POP;
            OP_SLEEP: state_d = S_INS;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_START:  state_d = S_DELTA;
      S_ZERO:   state_d = S_GO;
      S_POP:    if (!front_hit) state_d = S_TICK;
      S_TICK:   state_d = S_RESYNC;
      S_RESYNC: state_d = S_EVENT;
      S_EVENT:  state_d = S_DELTA;
      S_DELTA:  state_d = S_GO;
      S_GO:     state_d = S_WAIT;
      S_WAIT:   if (sc_done && emit_ok) state_d = S_IDLE;
      S_INS: begin
        priority if (full) begin
          if (emit_ok) state_d = S_IDLE;
        end else if (sooner) begin
          state_d = S_DELTA;
        end else if (emit_ok) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cur_d       = cur_q;
    cnt_d       = cnt_q;
    ntick_d     = ntick_q;
    prog_d      = prog_q;
    target_d    = target_q;
    delta_d     = delta_q;
    nt1_d       = nt1_q;
    exp_d       = exp_q;
    item_take_o = 1'b0;
    emit        = 1'b0;
    emit_res    = '0;
    ins_en      = 1'b0;
    pop_en      = 1'b0;
    scale_start = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          item_take_o = 1'b1;
          cur_d       = item_i;
        end
      end
      S_START: begin
        ntick_d  = cur_q.now + iv64;
        prog_d   = cur_q.now + iv64;
        target_d = cur_q.now + iv64;
        cnt_d    = '0;
        exp_d    = 1'b0;
      end
      S_ZERO: begin
        delta_d = iv64;
        exp_d   = 1'b1;
      end
      S_POP: begin
        if (front_hit && emit_ok) begin
          emit           = 1'b1;
          emit_res.kind  = KIND_WAKE;
          emit_res.woken = tk_q[0];
          pop_en         = 1'b1;
          cnt_d          = cnt_q - CW'(1);
        end
      end
      S_TICK: begin
        exp_d = cur_q.now >= ntick_q;
        nt1_d = ntick_q + iv64;
      end
      S_RESYNC: begin
        if (exp_q) ntick_d = (nt1_q <= cur_q.now) ? cur_q.now + iv64 : nt1_q;
      end
      S_EVENT: begin
        if (cnt_q != '0 && dl_q[0] < ntick_q) target_d = dl_q[0];
        else target_d = ntick_q;
        prog_d = target_d;
      end
      S_DELTA: begin
        delta_d = (target_q > cur_q.now) ? target_q - cur_q.now : 64'd0;
      end
      S_GO: scale_start = 1'b1;
      S_WAIT: begin
        if (sc_done && emit_ok) begin
          emit             = 1'b1;
          emit_res.kind    = KIND_PROG;
          emit_res.count   = sc_count;
          emit_res.expired = exp_q;
          emit_res.last    = 1'b1;
        end
      end
      S_INS: begin
        priority if (full) begin
          if (emit_ok) begin
            emit          = 1'b1;
            emit_res.kind = KIND_FULL;
            emit_res.last = 1'b1;
          end
        end else if (sooner || emit_ok) begin
          ins_en = 1'b1;
          cnt_d  = cnt_q + CW'(1);
          if (sooner) begin
            prog_d   = cur_q.deadline;
            target_d = cur_q.deadline;
            exp_d    = 1'b0;
          end else begin
            emit          = 1'b1;
            emit_res.kind = KIND_ACCEPT;
            emit_res.last = 1'b1;
          end
        end
      end
      default: ;
    endcase
    ov_d  = emit ? 1'b1 : (res_ready_i ? 1'b0 : ov_q);
    res_d = emit ? emit_res : res_q;
  end

  assign res_valid_o = ov_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ntick_q <= '0;
      prog_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ntick_q <= ntick_d;
      prog_q  <= prog_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    target_q <= target_d;
    delta_q  <= delta_d;
    nt1_q    <= nt1_d;
    exp_q    <= exp_d;
    res_q    <= res_d;
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_slot
    if (i == 0) begin : g_head
      always_ff @(posedge clk_i) begin
        if (pop_en) begin
          if (QUEUE_DEPTH > 1) begin
            dl_q[i] <= dl_q[(i + 1) % QUEUE_DEPTH];
            tk_q[i] <= tk_q[(i + 1) % QUEUE_DEPTH];
          end
        end else if (ins_en && !ge[i]) begin
          dl_q[i] <= cur_q.deadline;
          tk_q[i] <= cur_q.task_id;
        end
      end
    end else begin : g_body
      always_ff @(posedge clk_i) begin
        if (pop_en) begin
          if (i < QUEUE_DEPTH - 1) begin
            dl_q[i] <= dl_q[(i + 1) % QUEUE_DEPTH];
            tk_q[i] <= tk_q[(i + 1) % QUEUE_DEPTH];
          end
        end else if (ins_en && !ge[i]) begin
          dl_q[i] <= ge[i - 1] ? cur_q.deadline : dl_q[i - 1];
          tk_q[i] <= ge[i - 1] ? cur_q.task_id : tk_q[i - 1];
        end
      end
    end
  end

endmodule

// ===== design/tickless_deadline_timer_queue_top.sv =====
// Deadline-sorted sleep queue with a one-shot timer programmer. Input beats
// pass through a two-beat front queue into a sequencer that handles one item
// at a time. A start, a sleep that brings the earliest deadline, an interrupt
// (after one result beat per woken task) and an interrupt at time zero (which
// wakes no task) end in a count computation; a sleep that is only accepted or
// dropped as full does not. The count computation uses one 32x32 multiplier
// for four partial products, an accumulate and a shift. A stalled output
// holds the sequencer until the waiting beat is taken. Result beats leave
// through an output register, and the front queue keeps taking beats while
// it has room and a result waits.
module tickless_deadline_timer_queue_top
  import tdtq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  tdtq_in_if.sink     in_i,
  tdtq_out_if.source  out_o
);

  cfg_t  cfg_q;
  logic  item_valid, item_take, res_valid;
  item_t item;
  res_t  res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.interval <= INTERVAL_RST;
      cfg_q.mult     <= MULT_RST;
      cfg_q.shift    <= SHIFT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_INTERVAL: cfg_q.interval <= cfg_wdata_i[29:0];
        CFG_MULT:     cfg_q.mult     <= cfg_wdata_i;
        CFG_SHIFT:    cfg_q.shift    <= cfg_wdata_i[5:0];
        default: ;
      endcase
    end
  end

  tdtq_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .func_i       (in_i.func),
    .now_i        (in_i.now_ns),
    .task_i       (in_i.task_id),
    .deadline_i   (in_i.wake_deadline),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (item_take)
  );

  tdtq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_ready_i  (out_o.ready)
  );

  assign out_o.valid       = res_valid;
  assign out_o.kind        = res.kind;
  assign out_o.woken_task  = res.woken;
  assign out_o.timer_count = res.count;
  assign out_o.tick_passed = res.expired;
  assign out_o.last        = res.last;

endmodule

// ===== design/tdtq_chk.sv =====
module tdtq_chk
  import tdtq_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [31:0] out_count,
  input logic        out_expired,
  input logic        out_last
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_count))
    else $error("result beat changed while stalled");

  a_wake_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_kind == KIND_WAKE |-> !out_last)
    else $error("wake beat marked last");

  a_expired_prog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_expired |-> out_kind == KIND_PROG)
    else $error("tick expired on a non-program beat");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_kind == KIND_PROG |-> out_count != 32'd0 && out_last)
    else $error("program beat with zero count or not last");

endmodule

bind tickless_deadline_timer_queue_top tdtq_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .out_kind    (out_o.kind),
  .out_count   (out_o.timer_count),
  .out_expired (out_o.tick_passed),
  .out_last    (out_o.last)
);
